@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, idle while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true on a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/fcc_pkg.sv @@
package fcc_pkg;

  // Frame layout.
  localparam int unsigned HDR_BYTES       = 8;
  localparam int unsigned CRC_LEN_BYTES   = 2;
  localparam int unsigned CRC_PRESENT_DEF = 1;
  localparam int unsigned IDX_W           = 9;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  // Frame status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LEN   = 2'd2,
    ST_CRC   = 2'd3
  } status_t;

  // Control from the frame tracker to the CRC unit.
  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [7:0] data;
  } crc_ctl_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic       frame_end;
    status_t    status;
    logic [7:0] hdr_version;
    logic [7:0] hdr_network;
    logic [7:0] hdr_type;
    logic [7:0] hdr_source;
    logic [7:0] hdr_dest;
    logic [7:0] hdr_sequence;
    logic [7:0] hdr_flags;
    logic [7:0] hdr_payload_len;
  } result_t;

  // Byte-wide CRC-16/CCITT-FALSE update, MSB first.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/frame_checker_crc16.sv @@
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | in_data_byte, in_last_byte
// out_    | output    | out_valid/out_stall | payload byte, flags, status, header
// cfg_    | input     | cfg_wr_en         | cfg_wr_data (crc check enable)
//
// One byte per cycle sustained while the output is not stalled; each byte moves
// from the input register through the byte-wide CRC step and the frame decode
// into the output register, and its result is on the output from there.
// Reset is synchronous and active low; it clears all frame state and sets the
// CRC check enable. A stall on the output holds both registers, so in_stall rises
// only once the input register is full and cannot move on.
module frame_checker_crc16 #(
  parameter int unsigned CRC_PRESENT = fcc_pkg::CRC_PRESENT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_is_payload,
  output logic       out_frame_end,
  output logic [1:0] out_status,
  output logic [7:0] out_hdr_version,
  output logic [7:0] out_hdr_network,
  output logic [7:0] out_hdr_type,
  output logic [7:0] out_hdr_source,
  output logic [7:0] out_hdr_dest,
  output logic [7:0] out_hdr_sequence,
  output logic [7:0] out_hdr_flags,
  output logic [7:0] out_hdr_payload_len,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import fcc_pkg::*;
  `include "assert_macros.svh"

  logic        s1_valid_r, s1_last_r, out_valid_r, crc_en_r;
  logic [7:0]  s1_data_r;
  logic        s2_take, fire;
  logic [15:0] crc_nxt;
  crc_ctl_t    crc_ctl;
  result_t     res, out_r;

  // Pipeline advance.
  assign s2_take  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && s2_take;
  assign in_stall = s1_valid_r && !s2_take;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      crc_en_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  fcc_track #(
    .CRC_PRESENT(CRC_PRESENT)
  ) u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .data_byte        (s1_data_r),
    .last_byte        (s1_last_r),
    .crc_check_enable (crc_en_r),
    .crc_nxt          (crc_nxt),
    .crc_ctl          (crc_ctl),
    .result           (res)
  );

  fcc_crc u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (crc_ctl),
    .crc_nxt (crc_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_byte    = out_r.payload_byte;
  assign out_is_payload      = out_r.is_payload;
  assign out_frame_end       = out_r.frame_end;
  assign out_status          = out_r.status;
  assign out_hdr_version     = out_r.hdr_version;
  assign out_hdr_network     = out_r.hdr_network;
  assign out_hdr_type        = out_r.hdr_type;
  assign out_hdr_source      = out_r.hdr_source;
  assign out_hdr_dest        = out_r.hdr_dest;
  assign out_hdr_sequence    = out_r.hdr_sequence;
  assign out_hdr_flags       = out_r.hdr_flags;
  assign out_hdr_payload_len = out_r.hdr_payload_len;

  // Checks on the pipeline and the result fields.
  `ASSERT_CLK(a_stall_full, in_stall |-> (s1_valid_r && out_valid_r), "stall without full pipeline")
  `ASSERT_CLK(a_end_reaches_out, (fire && s1_last_r) |=> (out_valid && out_frame_end), "frame end lost")
  `ASSERT_NEVER(a_status_mid, out_valid && !out_frame_end && (out_status != ST_OK), "status mid frame")
  `ASSERT_NEVER(a_pay_zero, out_valid && !out_is_payload && (out_payload_byte != 8'h00), "stray payload byte")

endmodule

@@ rtl/fcc_crc.sv @@
module fcc_crc (
  input  logic              clk,
  input  logic              rst_n,
  input  fcc_pkg::crc_ctl_t ctl,
  output logic [15:0]       crc_nxt
);
  import fcc_pkg::*;

  logic [15:0] crc_r;

  // Value of the accumulator once the current byte is folded in.
  assign crc_nxt = ctl.feed ? crc16_feed(crc_r, ctl.data) : crc_r;

  // Accumulator restarts at the end of every frame.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

@@ rtl/fcc_track.sv @@
module fcc_track #(
  parameter int unsigned CRC_PRESENT = fcc_pkg::CRC_PRESENT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              crc_check_enable,
  input  logic [15:0]       crc_nxt,
  output fcc_pkg::crc_ctl_t crc_ctl,
  output fcc_pkg::result_t  result
);
  import fcc_pkg::*;

  localparam logic [IDX_W-1:0] HDR_IDX  = IDX_W'(HDR_BYTES);
  localparam logic [9:0]       TAIL_LEN = 10'(HDR_BYTES + CRC_LEN_BYTES * CRC_PRESENT);

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]       hdr_r   [HDR_BYTES];
  logic [7:0]       hdr_nxt [HDR_BYTES];
  logic [15:0]      rx_crc_r, rx_crc_nxt;
  logic [IDX_W-1:0] pay_end;
  logic             in_hdr, in_pay, active;
  logic [9:0]       expected;
  status_t          status;

  // Region decode for the current byte.
  assign active  = !byte_index_r[IDX_W-1];
  assign pay_end = HDR_IDX + IDX_W'(hdr_r[HDR_BYTES-1]);
  assign in_hdr  = active && (byte_index_r < HDR_IDX);
  assign in_pay  = active && !in_hdr && (byte_index_r < pay_end);

  // Header capture, received CRC capture and index advance.
  always_comb begin
    for (int j = 0; j < HDR_BYTES; j++) begin
      hdr_nxt[j] = hdr_r[j];
    end
    if (in_hdr) begin
      hdr_nxt[byte_index_r[2:0]] = data_byte;
    end
    rx_crc_nxt = rx_crc_r;
    if (CRC_PRESENT != 0 && active && !in_hdr && !in_pay) begin
      if (byte_index_r == pay_end) begin
        rx_crc_nxt[7:0] = data_byte;
      end else if (byte_index_r == pay_end + IDX_W'(1)) begin
        rx_crc_nxt[15:8] = data_byte;
      end
    end
    byte_index_nxt = active ? byte_index_r + IDX_W'(1) : byte_index_r;
  end

  assign crc_ctl.feed  = fire && (in_hdr || in_pay);
  assign crc_ctl.clear = fire && last_byte;
  assign crc_ctl.data  = data_byte;

  // End-of-frame verdict.
  assign expected = TAIL_LEN + 10'(hdr_nxt[HDR_BYTES-1]);
  always_comb begin
    if (byte_index_nxt < HDR_IDX) begin
      status = ST_SHORT;
    end else if (expected > 10'd255 || 10'(byte_index_nxt) != expected) begin
      status = ST_LEN;
    end else if (CRC_PRESENT != 0 && crc_check_enable && rx_crc_nxt != crc_nxt) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  // Result fields; zero where the byte carries no meaning.
  always_comb begin
    result.payload_byte    = in_pay ? data_byte : 8'h00;
    result.is_payload      = in_pay;
    result.frame_end       = last_byte;
    result.status          = last_byte ? status : ST_OK;
    result.hdr_version     = last_byte ? hdr_nxt[0] : 8'h00;
    result.hdr_network     = last_byte ? hdr_nxt[1] : 8'h00;
    result.hdr_type        = last_byte ? hdr_nxt[2] : 8'h00;
    result.hdr_source      = last_byte ? hdr_nxt[3] : 8'h00;
    result.hdr_dest        = last_byte ? hdr_nxt[4] : 8'h00;
    result.hdr_sequence    = last_byte ? hdr_nxt[5] : 8'h00;
    result.hdr_flags       = last_byte ? hdr_nxt[6] : 8'h00;
    result.hdr_payload_len = last_byte ? hdr_nxt[7] : 8'h00;
  end

  // Frame state; cleared by reset and after the marked byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      byte_index_r <= '0;
      rx_crc_r     <= '0;
      for (int j = 0; j < HDR_BYTES; j++) begin
        hdr_r[j] <= 8'h00;
      end
    end else if (fire) begin
      byte_index_r <= byte_index_nxt;
      rx_crc_r     <= rx_crc_nxt;
      for (int j = 0; j < HDR_BYTES; j++) begin
        hdr_r[j] <= hdr_nxt[j];
      end
    end
  end

endmodule
